// ===== design/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg
// shared constants, action codes and the store update control struct
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_BITS_DEF    = 16;
    localparam int VALUE_BITS_DEF  = 31;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam int RD_W = 32;

    typedef enum logic {
        ACT_GET = 1'b0,
        ACT_PUT = 1'b1
    } lkv_action_t;

    typedef struct packed {
        logic promote;      // move target slot to rank 0, age the more recent ones
        logic write_value;  // store the item value into the target slot
        logic write_key;    // store the key and mark the slot valid
        logic grow;         // a free slot was taken, bump the entry count
    } lkv_upd_t;

endpackage

// ===== design/lkv_store.sv =====
// ----------------------------------------------------------------------------
// lkv_store
// entry storage: valid bits, keys, values, recency ranks and entry count
// ----------------------------------------------------------------------------
module lkv_store #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = lkv_pkg::VALUE_BITS_DEF,
    parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  lkv_pkg::lkv_upd_t      upd,
    input  logic [IDX_W-1:0]       upd_slot,
    input  logic [CNT_W-1:0]       upd_thr,
    input  logic [KEY_BITS-1:0]    upd_key,
    input  logic [VALUE_BITS-1:0]  upd_value,
    output logic                   entry_valid [MAX_ENTRIES],
    output logic [KEY_BITS-1:0]    entry_key   [MAX_ENTRIES],
    output logic [VALUE_BITS-1:0]  entry_value [MAX_ENTRIES],
    output logic [IDX_W-1:0]       entry_rank  [MAX_ENTRIES],
    output logic [CNT_W-1:0]       entry_count
);
    import lkv_pkg::*;

    logic                  valid_reg [MAX_ENTRIES];
    logic                  valid_next [MAX_ENTRIES];
    logic [KEY_BITS-1:0]   key_reg [MAX_ENTRIES];
    logic [KEY_BITS-1:0]   key_next [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] value_reg [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] value_next [MAX_ENTRIES];
    logic [IDX_W-1:0]      rank_reg [MAX_ENTRIES];
    logic [IDX_W-1:0]      rank_next [MAX_ENTRIES];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            valid_next[i] = valid_reg[i];
            key_next[i]   = key_reg[i];
            value_next[i] = value_reg[i];
            rank_next[i]  = rank_reg[i];
            if (fire && (upd_slot == IDX_W'(i)))
            begin
                if (upd.write_key)
                begin
                    valid_next[i] = 1'b1;
                    key_next[i]   = upd_key;
                end
                if (upd.write_value)
                begin
                    value_next[i] = upd_value;
                end
                if (upd.promote)
                begin
                    rank_next[i] = '0;
                end
            end else if (fire && upd.promote && valid_reg[i]
                         && (CNT_W'(rank_reg[i]) < upd_thr))
            begin
                rank_next[i] = rank_reg[i] + 1'b1;
            end
        end
        count_next = count_reg;
        if (fire && upd.grow)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
            count_reg <= '0;
        end else
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                valid_reg[i] <= valid_next[i];
                rank_reg[i]  <= rank_next[i];
            end
            count_reg <= count_next;
        end
    end

    // payload, no reset: only read behind a valid bit
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            key_reg[i]   <= key_next[i];
            value_reg[i] <= value_next[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            entry_valid[i] = valid_reg[i];
            entry_key[i]   = key_reg[i];
            entry_value[i] = value_reg[i];
            entry_rank[i]  = rank_reg[i];
        end
        entry_count = count_reg;
    end

endmodule

// ===== design/lkv_lookup.sv =====
// ----------------------------------------------------------------------------
// lkv_lookup
// parallel key match, free slot and lru slot search, update decision
// ----------------------------------------------------------------------------
module lkv_lookup #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = lkv_pkg::VALUE_BITS_DEF,
    parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  lkv_pkg::lkv_action_t        action,
    input  logic [KEY_BITS-1:0]         key,
    input  logic [lkv_pkg::CAP_W-1:0]   capacity,
    input  logic                        entry_valid [MAX_ENTRIES],
    input  logic [KEY_BITS-1:0]         entry_key   [MAX_ENTRIES],
    input  logic [VALUE_BITS-1:0]       entry_value [MAX_ENTRIES],
    input  logic [IDX_W-1:0]            entry_rank  [MAX_ENTRIES],
    input  logic [CNT_W-1:0]            entry_count,
    output lkv_pkg::lkv_upd_t           upd,
    output logic [IDX_W-1:0]            upd_slot,
    output logic [CNT_W-1:0]            upd_thr,
    output logic                        hit,
    output logic [lkv_pkg::RD_W-1:0]    read_value
);
    import lkv_pkg::*;

    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic             is_put;
    logic             found;
    logic [IDX_W-1:0] hit_slot;
    logic             free_found;
    logic [IDX_W-1:0] free_slot;
    logic [IDX_W-1:0] lru_slot;
    logic             room;

    assign is_put = (action == ACT_PUT);

    // lowest index wins on every search
    always_comb
    begin
        found      = 1'b0;
        hit_slot   = '0;
        free_found = 1'b0;
        free_slot  = '0;
        lru_slot   = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (entry_valid[i] && (entry_key[i] == key))
            begin
                found    = 1'b1;
                hit_slot = IDX_W'(i);
            end
            if (!entry_valid[i])
            begin
                free_found = 1'b1;
                free_slot  = IDX_W'(i);
            end
            // valid ranks are a permutation of 0..count-1, oldest holds count-1
            if (entry_valid[i] && (CNT_W'(entry_rank[i]) == (entry_count - CNT_W'(1))))
            begin
                lru_slot = IDX_W'(i);
            end
        end
    end

    // capacity zero behaves as one, above the store size it saturates
    always_comb
    begin
        if (capacity == '0)
        begin
            room = (entry_count == '0);
        end else
        begin
            room = (CMP_W'(entry_count) < CMP_W'(capacity));
        end
        room = room && (CMP_W'(entry_count) < CMP_W'(MAX_ENTRIES)) && free_found;
    end

    always_comb
    begin
        upd.promote     = found || is_put;
        upd.write_value = is_put;
        upd.write_key   = is_put && !found;
        upd.grow        = is_put && !found && room;
        if (found)
        begin
            upd_slot = hit_slot;
            upd_thr  = CNT_W'(entry_rank[hit_slot]);
        end else if (room)
        begin
            upd_slot = free_slot;
            upd_thr  = entry_count;
        end else
        begin
            upd_slot = lru_slot;
            upd_thr  = entry_count;
        end
    end

    assign hit        = found;
    assign read_value = (!is_put && found) ? RD_W'(entry_value[hit_slot]) : {RD_W{1'b1}};

endmodule

// ===== design/lru_key_value_cache_core.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// path: a taken beat waits in the input register, then the combinational match
//   and rank update carry it into the result register once that is empty or read
// throughput: one access per clock while m_tready is high, set by that path
// reset: all entries invalid, ranks and count zero, capacity 16, no clearing
//   pass, so the first beat is taken right after reset
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = lkv_pkg::VALUE_BITS_DEF,
    parameter int S_DATA_W    = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [S_DATA_W-1:0]        s_tdata,   // key, value
    input  logic                       s_tuser,   // action
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [lkv_pkg::RD_W-1:0]   m_tdata,   // read_value
    output logic                       m_tuser,   // hit
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]  cfg_data   // capacity
);
    import lkv_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic                  in_valid_reg;
    logic                  in_action_reg;
    logic [KEY_BITS-1:0]   in_key_reg;
    logic [VALUE_BITS-1:0] in_value_reg;
    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [RD_W-1:0]       out_data_reg;
    logic [CAP_W-1:0]      capacity_reg;

    logic                  advance;
    logic                  take;

    logic                  entry_valid [MAX_ENTRIES];
    logic [KEY_BITS-1:0]   entry_key   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] entry_value [MAX_ENTRIES];
    logic [IDX_W-1:0]      entry_rank  [MAX_ENTRIES];
    logic [CNT_W-1:0]      entry_count;

    lkv_upd_t              upd;
    logic [IDX_W-1:0]      upd_slot;
    logic [CNT_W-1:0]      upd_thr;
    logic                  hit;
    logic [RD_W-1:0]       read_value;
    lkv_action_t           action;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign take      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign action    = lkv_action_t'(in_action_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= CAP_RESET;
        end else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_action_reg <= s_tuser;
            in_key_reg    <= s_tdata[KEY_BITS-1:0];
            in_value_reg  <= s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
        end
        if (advance)
        begin
            out_hit_reg  <= hit;
            out_data_reg <= read_value;
        end
    end

    lkv_lookup #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_lookup (
        .action      (action),
        .key         (in_key_reg),
        .capacity    (capacity_reg),
        .entry_valid (entry_valid),
        .entry_key   (entry_key),
        .entry_value (entry_value),
        .entry_rank  (entry_rank),
        .entry_count (entry_count),
        .upd         (upd),
        .upd_slot    (upd_slot),
        .upd_thr     (upd_thr),
        .hit         (hit),
        .read_value  (read_value)
    );

    lkv_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .upd         (upd),
        .upd_slot    (upd_slot),
        .upd_thr     (upd_thr),
        .upd_key     (in_key_reg),
        .upd_value   (in_value_reg),
        .entry_valid (entry_valid),
        .entry_key   (entry_key),
        .entry_value (entry_value),
        .entry_rank  (entry_rank),
        .entry_count (entry_count)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== tb/lru_key_value_cache_core_tb.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_core_tb
// self-checking bench for the lru key-value cache: a directed opening on the
// field extremes and the capacity corner cases, then random get/put traffic on
// small key pools under several capacities and idle patterns; every result
// beat is checked against a cycle-free cache predictor kept in the bench
// ----------------------------------------------------------------------------
module lru_key_value_cache_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lkv_pkg::*;

    localparam int NUM_SLOTS = MAX_ENTRIES_DEF;
    localparam int KB        = KEY_BITS_DEF;
    localparam int VB        = VALUE_BITS_DEF;
    localparam int TDATA_W   = ((KB + VB + 7) / 8) * 8;
    localparam int BLOCK_LEN = 45;
    localparam int HOLD_CYCLES = 150;
    localparam logic [CAP_W-1:0] CAP_PLAN [9] = '{16, 1, 4, 31, 3, 17, 8, 2, 0};

    typedef struct packed {
        lkv_action_t     act;
        logic [KB-1:0]   key;
        logic [VB-1:0]   val;
    } cache_req_t;

    typedef struct packed {
        logic              hit;
        logic [RD_W-1:0]   read_value;
    } lookup_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata   = '0;   // key, value
    logic                  s_tuser   = 1'b0; // action
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [RD_W-1:0]       m_tdata;          // read_value
    logic                  m_tuser;          // hit
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CAP_W-1:0]      cfg_data  = '0;   // capacity

    cache_req_t      pend_reqs[$];
    lookup_result_t  expected_lookups[$];
    int              mismatch_count = 0;
    int              tx_idle_pct    = 0;
    int              rx_idle_pct    = 0;
    logic            rx_hold        = 1'b0;
    logic            hold_request   = 1'b0;

    // predictor state
    logic [CAP_W-1:0]  cap_reg = CAP_RESET;
    logic              mdl_valid [NUM_SLOTS];
    logic [KB-1:0]     mdl_key   [NUM_SLOTS];
    logic [VB-1:0]     mdl_val   [NUM_SLOTS];
    int unsigned       mdl_rank  [NUM_SLOTS];
    int unsigned       mdl_count = 0;

    lru_key_value_cache_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // cache predictor
    // ------------------------------------------------------------------------
    function automatic void move_to_front(int s, int unsigned old_rank);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (mdl_valid[i] && i != s && mdl_rank[i] < old_rank)
                mdl_rank[i]++;
        end
        mdl_rank[s] = 0;
    endfunction

    function automatic lookup_result_t cache_access(lkv_action_t act, logic [KB-1:0] k,
                                                    logic [VB-1:0] v);
        lookup_result_t r;
        int slot;
        int unsigned lim;
        slot = -1;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (slot < 0 && mdl_valid[i] && mdl_key[i] == k)
                slot = i;
        end
        r.hit        = (slot >= 0);
        r.read_value = '1;
        if (slot >= 0)
        begin
            if (act == ACT_GET)
                r.read_value = {1'b0, mdl_val[slot]};
            else
                mdl_val[slot] = v;
            move_to_front(slot, mdl_rank[slot]);
        end
        else if (act == ACT_PUT)
        begin
            lim = (cap_reg == 0) ? 1 : ((cap_reg > NUM_SLOTS) ? NUM_SLOTS : cap_reg);
            if (mdl_count < lim)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot < 0 && !mdl_valid[i])
                        slot = i;
                end
                mdl_valid[slot] = 1'b1;
                mdl_key[slot]   = k;
                mdl_val[slot]   = v;
                mdl_count++;
                // a fresh entry ranks below every held one
                move_to_front(slot, mdl_count);
            end
            else
            begin
                // evict the least recent valid entry, count unchanged
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (mdl_valid[i] && (slot < 0 || mdl_rank[i] > mdl_rank[slot]))
                        slot = i;
                end
                mdl_key[slot] = k;
                mdl_val[slot] = v;
                move_to_front(slot, mdl_rank[slot]);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t ns: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // request driver, predicts on every accepted beat
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cache_req_t req;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                expected_lookups = {expected_lookups,
                                    cache_access(lkv_action_t'(s_tuser),
                                                 s_tdata[KB-1:0],
                                                 s_tdata[KB+VB-1:KB])};
            if (!s_tvalid || s_tready)
            begin
                if (pend_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    req = pend_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= req.act;
                    s_tdata  <= TDATA_W'({req.val, req.key});
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        lookup_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_lookups.size() == 0)
                report_mismatch($sformatf("unexpected result beat hit=%0b data=%h",
                                          m_tuser, m_tdata));
            else
            begin
                exp_r = expected_lookups.pop_front();
                if (m_tuser !== exp_r.hit)
                    report_mismatch($sformatf("hit %b, expected %b", m_tuser, exp_r.hit));
                if (m_tdata !== exp_r.read_value)
                    report_mismatch($sformatf("read_value %h, expected %h",
                                              m_tdata, exp_r.read_value));
            end
        end
    end

    // long receiver stall so the input side backs up
    initial
    begin
        wait (hold_request);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #400_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_req(lkv_action_t act, logic [KB-1:0] k, logic [VB-1:0] v);
        cache_req_t req;
        req.act = act;
        req.key = k;
        req.val = v;
        pend_reqs = {pend_reqs, req};
    endtask

    // sampled at the falling edge so the driver's pops and beats have settled
    task automatic wait_drained();
        @(negedge clk);
        while (pend_reqs.size() != 0 || s_tvalid || expected_lookups.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] c);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do
            @(posedge clk);
        while (!cfg_ready);
        cap_reg = c;
        cfg_valid <= 1'b0;
    endtask

    task automatic push_random(int n, int pool);
        int unsigned base;
        logic [KB-1:0] k;
        lkv_action_t act;
        base = $urandom_range(0, (1 << KB) - 1 - pool);
        for (int i = 0; i < n; i++)
        begin
            act = ($urandom_range(99) < 55) ? ACT_PUT : ACT_GET;
            // mostly a small pool so hits and evictions happen, some wild keys
            if ($urandom_range(9) == 0)
                k = KB'($urandom_range(0, (1 << KB) - 1));
            else
                k = KB'(base + $urandom_range(0, pool - 1));
            push_req(act, k, VB'($urandom));
        end
    endtask

    initial
    begin
        int eff;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            mdl_valid[i] = 1'b0;
            mdl_key[i]   = '0;
            mdl_val[i]   = '0;
            mdl_rank[i]  = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // field extremes, update and miss at reset capacity
        push_req(ACT_GET, '0, '0);
        push_req(ACT_PUT, '0, '0);
        push_req(ACT_PUT, '1, '1);
        push_req(ACT_GET, '0, '1);
        push_req(ACT_GET, '1, '0);
        push_req(ACT_PUT, '0, 31'h5555_5555);
        push_req(ACT_GET, '0, '0);
        push_req(ACT_GET, 16'h1234, '0);

        // capacity dropped below the held count: inserts replace, count holds
        write_capacity(5'd1);
        push_req(ACT_PUT, 16'h00aa, 31'h1);
        push_req(ACT_GET, '1, '0);
        push_req(ACT_GET, '0, '0);
        push_req(ACT_GET, 16'h00aa, '0);
        push_req(ACT_PUT, 16'h00bb, 31'h2);

        // zero capacity acts as one
        write_capacity(5'd0);
        push_req(ACT_PUT, 16'h00cc, 31'h3);
        push_req(ACT_GET, 16'h00bb, '0);
        push_req(ACT_GET, 16'h00cc, '0);

        // oversize capacity saturates
        write_capacity(5'd31);
        push_req(ACT_PUT, 16'h0001, 31'h2aaa_aaaa);
        push_req(ACT_PUT, 16'h0002, 31'h7fff_fffe);
        push_req(ACT_GET, 16'h0001, '0);

        for (int blk = 0; blk < 9; blk++)
        begin
            write_capacity(CAP_PLAN[blk]);
            if (blk < 3)
            begin
                tx_idle_pct = 32;
                rx_idle_pct = 80;
            end
            else if (blk < 6)
            begin
                tx_idle_pct = 80;
                rx_idle_pct = 32;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (blk == 7)
                hold_request = 1'b1;
            eff = (CAP_PLAN[blk] == 0) ? 1 :
                  ((CAP_PLAN[blk] > NUM_SLOTS) ? NUM_SLOTS : CAP_PLAN[blk]);
            push_random(BLOCK_LEN, eff + 1 + $urandom_range(0, 6));
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_lookups.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lkv_pkg.sv
design/lkv_store.sv
design/lkv_lookup.sv
design/lru_key_value_cache_core.sv
tb/lru_key_value_cache_core_tb.sv
